// File: sv/hrlp_pkg.sv
// shared types, codes and match tables for the http request line parser
`default_nettype none

package hrlp_pkg;

    // parse phase of the current line
    typedef enum logic [1:0] {
        PH_METHOD  = 2'd0,
        PH_TARGET  = 2'd1,
        PH_VERSION = 2'd2,
        PH_AFTER   = 2'd3
    } phase_t;

    // tag of one output character
    typedef enum logic [1:0] {
        KIND_DISCARD = 2'd0,
        KIND_PATH    = 2'd1,
        KIND_QUERY   = 2'd2
    } kind_t;

    // verdict codes on the final character
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_METHOD  = 3'd1,
        ST_BAD_TARGET  = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_QUOTE       = 3'd4
    } status_t;

    // bit positions in the error flag word
    localparam int unsigned ERR_METHOD  = 0;
    localparam int unsigned ERR_TARGET  = 1;
    localparam int unsigned ERR_VERSION = 2;
    localparam int unsigned ERR_QUOTE   = 3;

    localparam int unsigned ERR_W = 4;
    localparam int unsigned POS_W = 4;

    localparam logic [POS_W-1:0] POS_MAX     = 4'd15;
    localparam logic [POS_W-1:0] METHOD_LEN  = 4'd3;
    localparam logic [POS_W-1:0] VERSION_LEN = 4'd8;

    // character constants
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // one input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_line;
    } req_item_t;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       line_done;
        logic [2:0] status;
    } res_item_t;

    // parser state visible to the top level
    typedef struct packed {
        phase_t           phase;
        logic [POS_W-1:0] match_position;
    } core_state_t;

    // expected method character at a position
    function automatic logic [7:0] method_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = 8'h47; // G
            2'd1:    ch = 8'h45; // E
            2'd2:    ch = 8'h54; // T
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // expected version character at a position
    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h48; // H
            3'd1:    ch = 8'h54; // T
            3'd2:    ch = 8'h54; // T
            3'd3:    ch = 8'h50; // P
            3'd4:    ch = 8'h2F; // /
            3'd5:    ch = 8'h31; // 1
            3'd6:    ch = 8'h2E; // .
            default: ch = 8'h31; // 1
        endcase
        return ch;
    endfunction

    // saturating position increment
    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] pos);
        return (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
    endfunction

endpackage

`default_nettype wire

// File: sv/http_request_line_parser.sv
// http request line parser top level: input register, parse core, result register
//
// Usage: characters of one request line enter on the req channel, one per
// transaction, with end_of_line set on the final character. Each character
// yields exactly one transaction on the res channel that passes the byte
// through and tags it as discarded, path or query. The result of the final
// character carries line_done and the verdict in status; the parser then
// starts the next line from its reset state.
// Both channels are valid/stall: a transaction moves when valid is high and
// stall is low at a rising clock edge.
// The accepting edge loads the input register; an advancing edge later moves the parsed
// transaction into the result register, raising res_valid.
// Throughput is one character per cycle while res_stall is low, set by the parse state
// update between the two registers.
// When res_stall is held, the result register keeps its transaction, the input
// register fills, and req_stall rises; no transaction is dropped or repeated.
// rst_n is asynchronous and active low: it empties both registers and returns
// the parser to the start of a line.
`default_nettype none

module http_request_line_parser (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_stall,
    input  hrlp_pkg::req_item_t  req_data,
    output logic                 res_valid,
    input  wire                  res_stall,
    output hrlp_pkg::res_item_t  res_data
);
    import hrlp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    req_item_t    in_data_reg;
    logic         out_valid_reg, out_valid_next;
    res_item_t    out_data_reg;
    logic         advance;
    res_item_t    core_result;
    core_state_t  core_state;

    // stage transfer and back pressure
    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign req_stall = in_valid_reg && !advance;

    assign in_valid_next  = req_stall ? 1'b1 : req_valid;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && res_stall);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_data_reg <= req_data;
        if (advance)
            out_data_reg <= core_result;
    end

    hrlp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .result  (core_result),
        .state   (core_state)
    );

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg && out_valid_reg && res_stall)
        else $error("req_stall without a held transaction");

    a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.line_done |-> res_data.status == ST_OK)
        else $error("status set on a transaction that is not line end");

    a_reset_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.end_of_line |=>
            core_state.phase == PH_METHOD && core_state.match_position == '0)
        else $error("parser did not return to line start");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.out_kind != 2'd3)
        else $error("illegal out_kind");

endmodule

`default_nettype wire

// File: sv/hrlp_parse_core.sv
// per-character parse state machine and result logic
`default_nettype none

module hrlp_parse_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     advance,
    input  hrlp_pkg::req_item_t     item,
    output hrlp_pkg::res_item_t     result,
    output hrlp_pkg::core_state_t   state
);
    import hrlp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic              in_query_reg, in_query_next;
    logic              started_reg, started_next;

    logic [7:0]        c;
    kind_t             kind;
    status_t           verdict;
    logic [ERR_W-1:0]  final_flags;

    assign c = item.in_byte;

    // state registers, updated once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD;
            pos_reg      <= '0;
            err_reg      <= '0;
            in_query_reg <= 1'b0;
            started_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            err_reg      <= err_next;
            in_query_reg <= in_query_next;
            started_reg  <= started_next;
        end
    end

    // next state, tag and verdict for the current character
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        err_next      = err_reg;
        in_query_next = in_query_reg;
        started_next  = started_reg;
        kind          = KIND_DISCARD;
        verdict       = ST_OK;
        final_flags   = '0;

        unique case (phase_reg)
            PH_METHOD:
            begin
                if (c == CH_SPACE)
                begin
                    if (pos_reg != METHOD_LEN)
                        err_next[ERR_METHOD] = 1'b1;
                    phase_next = PH_TARGET;
                    pos_next   = '0;
                end
                else
                begin
                    if (pos_reg >= METHOD_LEN || c != method_char(pos_reg[1:0]))
                        err_next[ERR_METHOD] = 1'b1;
                    pos_next = bump(pos_reg);
                end
            end
            PH_TARGET:
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    if (c != CH_SLASH)
                        err_next[ERR_TARGET] = 1'b1;
                end
                if (c == CH_SPACE)
                begin
                    phase_next = PH_VERSION;
                    pos_next   = '0;
                end
                else if (in_query_reg)
                    kind = KIND_QUERY;
                else if (c == CH_QMARK)
                    in_query_next = 1'b1;
                else
                begin
                    kind = KIND_PATH;
                    if (c == CH_QUOTE)
                        err_next[ERR_QUOTE] = 1'b1;
                end
            end
            PH_VERSION:
            begin
                if (pos_reg >= VERSION_LEN || c != version_char(pos_reg[2:0]))
                    err_next[ERR_VERSION] = 1'b1;
                pos_next = bump(pos_reg);
                if (pos_next >= VERSION_LEN)
                    phase_next = PH_AFTER;
            end
            PH_AFTER:
            begin
                err_next[ERR_VERSION] = 1'b1;
            end
            default:
            begin
                err_next[ERR_VERSION] = 1'b1;
            end
        endcase

        // verdict on the final character, then back to the start of a line
        if (item.end_of_line)
        begin
            final_flags = err_next;
            if (phase_next == PH_METHOD)
            begin
                if (pos_next != METHOD_LEN)
                    final_flags[ERR_METHOD] = 1'b1;
                else
                    final_flags[ERR_TARGET] = 1'b1;
            end
            else if (phase_next == PH_TARGET)
            begin
                if (!started_next)
                    final_flags[ERR_TARGET] = 1'b1;
                final_flags[ERR_VERSION] = 1'b1;
            end
            else if (phase_next == PH_VERSION)
                final_flags[ERR_VERSION] = 1'b1;

            if (final_flags[ERR_METHOD])
                verdict = ST_BAD_METHOD;
            else if (final_flags[ERR_TARGET])
                verdict = ST_BAD_TARGET;
            else if (final_flags[ERR_VERSION])
                verdict = ST_BAD_VERSION;
            else if (final_flags[ERR_QUOTE])
                verdict = ST_QUOTE;
            else
                verdict = ST_OK;

            phase_next    = PH_METHOD;
            pos_next      = '0;
            err_next      = '0;
            in_query_next = 1'b0;
            started_next  = 1'b0;
        end
    end

    // result fields
    assign result.out_byte  = c;
    assign result.out_kind  = kind;
    assign result.line_done = item.end_of_line;
    assign result.status    = verdict;

    assign state.phase          = phase_reg;
    assign state.match_position = pos_reg;

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking testbench for the http request line parser
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlp_pkg::*;

    localparam int unsigned RANDOM_CHARS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRILL_LEN    = 27;
    localparam int unsigned SHOW_MAX     = 10;

    localparam logic [23:0] METHOD_WORD  = "GET";
    localparam logic [63:0] VERSION_WORD = "HTTP/1.1";
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_LF        = 8'h0A;

    // one directed row: character, end flag, and a hand-written verdict where obvious
    typedef struct {
        logic [7:0] ch;
        logic       eol;
        bit         typed;
        res_item_t  want;
    } drill_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_data;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_data;

    // parser state mirrored by the predictor
    phase_t      line_phase = PH_METHOD;
    logic [3:0]  match_pos  = '0;
    logic [3:0]  err_seen   = '0;
    logic        query_open = 1'b0;
    logic        target_hit = 1'b0;

    res_item_t   tags_due[$];
    logic [7:0]  line_q[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned chars_sent  = 0;
    int unsigned lines_sent  = 0;
    int unsigned verdicts[5] = '{default: 0};
    int unsigned burst_left  = 0;
    bit          sender_calm = 1'b0;
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;

    drill_row_t drill_rows[DRILL_LEN] = '{
        // lone zero byte right after reset: method too short
        '{8'h00, 1'b1, 1'b1, '{8'h00, KIND_DISCARD, 1'b1, ST_BAD_METHOD}},
        // empty method
        '{CH_SPACE, 1'b1, 1'b1, '{CH_SPACE, KIND_DISCARD, 1'b1, ST_BAD_METHOD}},
        // line ends right after the method
        '{"G", 1'b0, 1'b0, '0},
        '{"E", 1'b0, 1'b0, '0},
        '{"T", 1'b1, 1'b1, '{"T", KIND_DISCARD, 1'b1, ST_BAD_TARGET}},
        // empty target, two spaces in a row
        '{"G", 1'b0, 1'b0, '0},
        '{"E", 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, '0},
        '{CH_SPACE, 1'b0, 1'b0, '0},
        '{CH_SPACE, 1'b1, 1'b1, '{CH_SPACE, KIND_DISCARD, 1'b1, ST_BAD_TARGET}},
        // full line with a quote in the path and a query byte of all ones
        '{"G", 1'b0, 1'b0, '0},
        '{"E", 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, '0},
        '{CH_SPACE, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_QMARK, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_QUERY, 1'b0, ST_OK}},
        '{CH_SPACE, 1'b0, 1'b0, '0},
        '{"H", 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, '0},
        '{"P", 1'b0, 1'b0, '0},
        '{"/", 1'b0, 1'b0, '0},
        '{"1", 1'b0, 1'b0, '0},
        '{".", 1'b0, 1'b0, '0},
        '{"1", 1'b1, 1'b1, '{"1", KIND_DISCARD, 1'b1, ST_QUOTE}}
    };

    http_request_line_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // saturating match counter
    function automatic logic [3:0] pos_next(input logic [3:0] pos);
        return (pos == 4'd15) ? pos : pos + 4'd1;
    endfunction

    // predict the tag of one character and advance the mirrored parser
    function automatic res_item_t tag_char(input logic [7:0] ch, input logic eol);
        kind_t      kind;
        status_t    verdict;
        logic [3:0] flags_now;
        kind    = KIND_DISCARD;
        verdict = ST_OK;
        case (line_phase)
            PH_METHOD:
            begin
                if (ch == CH_SPACE)
                begin
                    if (match_pos != METHOD_LEN)
                        err_seen[ERR_METHOD] = 1'b1;
                    line_phase = PH_TARGET;
                    match_pos  = '0;
                end
                else
                begin
                    if (match_pos >= METHOD_LEN)
                        err_seen[ERR_METHOD] = 1'b1;
                    else if (ch != METHOD_WORD[8 * (2 - match_pos[1:0]) +: 8])
                        err_seen[ERR_METHOD] = 1'b1;
                    match_pos = pos_next(match_pos);
                end
            end
            PH_TARGET:
            begin
                if (!target_hit)
                begin
                    target_hit = 1'b1;
                    if (ch != CH_SLASH)
                        err_seen[ERR_TARGET] = 1'b1;
                end
                if (ch == CH_SPACE)
                begin
                    line_phase = PH_VERSION;
                    match_pos  = '0;
                end
                else if (query_open)
                    kind = KIND_QUERY;
                else if (ch == CH_QMARK)
                    query_open = 1'b1;
                else
                begin
                    kind = KIND_PATH;
                    if (ch == CH_QUOTE)
                        err_seen[ERR_QUOTE] = 1'b1;
                end
            end
            PH_VERSION:
            begin
                if (match_pos >= VERSION_LEN
                    || ch != VERSION_WORD[8 * (7 - match_pos[2:0]) +: 8])
                    err_seen[ERR_VERSION] = 1'b1;
                match_pos = pos_next(match_pos);
                if (match_pos >= VERSION_LEN)
                    line_phase = PH_AFTER;
            end
            default:
                err_seen[ERR_VERSION] = 1'b1;
        endcase

        // verdict on the final character, judging an early end too
        if (eol)
        begin
            flags_now = err_seen;
            if (line_phase == PH_METHOD)
            begin
                if (match_pos != METHOD_LEN)
                    flags_now[ERR_METHOD] = 1'b1;
                else
                    flags_now[ERR_TARGET] = 1'b1;
            end
            else if (line_phase == PH_TARGET)
            begin
                if (!target_hit)
                    flags_now[ERR_TARGET] = 1'b1;
                flags_now[ERR_VERSION] = 1'b1;
            end
            else if (line_phase == PH_VERSION)
                flags_now[ERR_VERSION] = 1'b1;

            if (flags_now[ERR_METHOD])
                verdict = ST_BAD_METHOD;
            else if (flags_now[ERR_TARGET])
                verdict = ST_BAD_TARGET;
            else if (flags_now[ERR_VERSION])
                verdict = ST_BAD_VERSION;
            else if (flags_now[ERR_QUOTE])
                verdict = ST_QUOTE;

            line_phase = PH_METHOD;
            match_pos  = '0;
            err_seen   = '0;
            query_open = 1'b0;
            target_hit = 1'b0;
        end
        return '{out_byte: ch, out_kind: kind, line_done: eol, status: verdict};
    endfunction

    // random character for a path or query
    function automatic logic [7:0] target_char();
        int unsigned r;
        r = $urandom_range(0, 29);
        if (r == 0)
            return CH_QUOTE;
        if (r == 1)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    // send one character in bursts with random gaps, then log its expected tag
    task automatic drive_char(input logic [7:0] ch, input logic eol,
                              input bit typed, input res_item_t typed_res);
        int unsigned gap;
        res_item_t   predicted;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= '{in_byte: ch, end_of_line: eol};
        do
            @(posedge clk);
        while (req_stall);
        predicted = tag_char(ch, eol);
        tags_due.push_back(typed ? typed_res : predicted);
        chars_sent++;
        if (eol)
            lines_sent++;
    endtask

    // build one random request line, mostly well formed
    task automatic build_line();
        int unsigned shape;
        int unsigned n;
        logic [7:0]  ch;
        line_q.delete();
        shape = $urandom_range(0, 99);

        // pure noise
        if (shape < 10)
        begin
            n = $urandom_range(1, 20);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // method, sometimes mangled
        if (shape < 20)
        begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                if (i < 3 && $urandom_range(0, 1) == 1)
                    line_q.push_back(METHOD_WORD[8 * (2 - i) +: 8]);
                else
                    line_q.push_back(8'($urandom_range(65, 90)));
        end
        else
            for (int i = 0; i < 3; i++)
                line_q.push_back(METHOD_WORD[8 * (2 - i) +: 8]);
        line_q.push_back(CH_SPACE);

        // target: path, then maybe a query
        if (shape < 28)
        begin
            ch = 8'($urandom_range(0, 255));
            line_q.push_back(ch == CH_SLASH ? CH_SPACE : ch);
        end
        else
            line_q.push_back(CH_SLASH);
        n = $urandom_range(0, 10);
        repeat (n) line_q.push_back(target_char());
        if ($urandom_range(0, 1) == 1)
        begin
            line_q.push_back(CH_QMARK);
            n = $urandom_range(0, 8);
            repeat (n) line_q.push_back(target_char());
        end
        line_q.push_back(CH_SPACE);

        // version, sometimes broken
        for (int i = 0; i < 8; i++)
            line_q.push_back(VERSION_WORD[8 * (7 - i) +: 8]);
        if (shape >= 28 && shape < 38)
        begin
            case ($urandom_range(0, 2))
                0: line_q[line_q.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(0, 255));
                1: repeat ($urandom_range(1, 3)) void'(line_q.pop_back());
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: line_q.push_back(CH_CR);
                        1: line_q.push_back(CH_LF);
                        2: line_q.push_back(CH_SPACE);
                        default: line_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            endcase
        end

        // line cut short
        if (shape >= 38 && shape < 46)
        begin
            n = $urandom_range(1, line_q.size());
            while (line_q.size() > n)
                void'(line_q.pop_back());
        end
    endtask

    // result side stall, switching between quiet, random, periodic and heavy stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        else
            stall_left--;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 2) == 0);
            2: res_stall <= (cycle_count % 5 < 3);
            default: res_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // compare every accepted result with the oldest expected tag
    always @(posedge clk)
    begin : watch_results
        res_item_t want;
        res_item_t got;
        if (rst_n && res_valid && !res_stall)
        begin
            got = res_data;
            if (tags_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected transaction: byte %h kind %0d done %b status %0d",
                             got.out_byte, got.out_kind, got.line_done, got.status);
            end
            else
            begin
                want = tags_due.pop_front();
                if (got.out_byte !== want.out_byte || got.out_kind !== want.out_kind
                    || got.line_done !== want.line_done || got.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch: exp byte %h kind %0d done %b status %0d, %s",
                                 want.out_byte, want.out_kind, want.line_done, want.status,
                                 $sformatf("got byte %h kind %0d done %b status %0d",
                                           got.out_byte, got.out_kind, got.line_done,
                                           got.status));
                end
                if (want.line_done)
                    verdicts[want.status]++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // reset, directed table, random lines, drain
    initial
    begin : run_stimulus
        int unsigned random_start;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        res_stall = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DRILL_LEN; i++)
            drive_char(drill_rows[i].ch, drill_rows[i].eol, drill_rows[i].typed,
                       drill_rows[i].want);

        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            build_line();
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < line_q.size(); i++)
                drive_char(line_q[i], i == line_q.size() - 1, 1'b0, '0);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (tags_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("summary: %0d characters in %0d lines over %0d cycles, %0d mismatches",
                 chars_sent, lines_sent, cycle_count, mismatches);
        $display("summary: verdicts ok %0d, method %0d, target %0d, version %0d, quote %0d",
                 verdicts[0], verdicts[1], verdicts[2], verdicts[3], verdicts[4]);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
sv/hrlp_pkg.sv
sv/hrlp_parse_core.sv
sv/http_request_line_parser.sv
bench/tb.sv
